@@ rtl/vmf_pkg.sv @@
// Shared types and constants of the variable-length message FIFO.
// Used by vmf_ctrl, vmf_dp and variable_length_message_fifo_top; depends on nothing.
`default_nettype none

package vmf_pkg;

  // Storage geometry
  localparam int unsigned ENTRIES = 64;
  localparam int unsigned BYTES   = 512;

  // Fixed field widths of the channels
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned LEN_W    = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Internal widths follow from the geometry
  localparam int unsigned BPTR_W = $clog2(BYTES);
  localparam int unsigned USED_W = $clog2(BYTES + 1);
  localparam int unsigned DPTR_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned DESC_W = BPTR_W + LEN_W;
  localparam int unsigned CMP_W  = (USED_W > LEN_W) ? USED_W : LEN_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DESC,
    S_BYTE,
    S_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the input beat
    logic do_write;   // execute a write byte
    logic do_flush;   // return all pointers and counts to reset
    logic set_ok;     // result: ok with zero read fields
    logic set_empty;  // result: empty
    logic rd_desc;    // fetch the head descriptor
    logic rd_byte;    // fetch the byte at the read pointer
    logic load_head;  // take the fetched descriptor, fetch its first byte
    logic rd_finish;  // take the fetched byte and advance the reader
    logic out_load;   // move the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e cmd;       // latched command
    logic rd_empty;  // no message in progress and none stored
    logic rd_idle;   // reader not inside a message
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/vmf_ctrl.sv @@
// Sequencer of the message FIFO: steps each accepted beat through execute,
// memory fetches and result hand-off. Depends on vmf_pkg.
`default_nettype none

module vmf_ctrl
  import vmf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat_i.cmd)
          CMD_WRITE: begin
            cmd_o.do_write = 1'b1;
            state_d        = S_RESP;
          end
          CMD_READ: begin
            if (stat_i.rd_empty) begin
              cmd_o.set_empty = 1'b1;
              state_d         = S_RESP;
            end else if (stat_i.rd_idle) begin
              cmd_o.rd_desc = 1'b1;
              state_d       = S_DESC;
            end else begin
              cmd_o.rd_byte = 1'b1;
              state_d       = S_BYTE;
            end
          end
          CMD_QUERY: begin
            cmd_o.set_ok = 1'b1;
            state_d      = S_RESP;
          end
          CMD_FLUSH: begin
            cmd_o.do_flush = 1'b1;
            cmd_o.set_ok   = 1'b1;
            state_d        = S_RESP;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_DESC: begin
        cmd_o.load_head = 1'b1;
        state_d         = S_BYTE;
      end
      S_BYTE: begin
        cmd_o.rd_finish = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/vmf_dp.sv @@
// Datapath of the message FIFO: byte store, descriptor ring, ring pointers,
// counts and the output register. Depends on vmf_pkg; driven by vmf_ctrl.
`default_nettype none

module vmf_dp
  import vmf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctrl_cmd_t          cmd_i,
  output dp_stat_t                stat_o,
  input  wire logic [CMD_W-1:0]   command_i,
  input  wire logic [DATA_W-1:0]  data_byte_i,
  input  wire logic [LEN_W-1:0]   message_length_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic [DATA_W-1:0]       read_byte_o,
  output logic                    last_byte_o,
  output logic [LEN_W-1:0]        head_size_o,
  output logic [COUNT_W-1:0]      entry_count_o,
  output logic [COUNT_W-1:0]      high_water_o
);

  // Memories
  logic [DATA_W-1:0] byte_mem [BYTES];
  logic [DESC_W-1:0] desc_mem [ENTRIES];

  // Latched input beat
  cmd_e              cmd_q;
  logic [DATA_W-1:0] data_q;
  logic [LEN_W-1:0]  len_q;

  // Ring state
  logic [BPTR_W-1:0] wptr_q, wptr_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [DPTR_W-1:0] din_q, din_d;
  logic [DPTR_W-1:0] dout_q, dout_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  peak_q, peak_d;
  logic [LEN_W-1:0]  wleft_q, wleft_d;
  logic              discard_q, discard_d;
  logic [BPTR_W-1:0] rptr_q, rptr_d;
  logic [LEN_W-1:0]  rleft_q, rleft_d;
  logic              out_valid_q, out_valid_d;

  // Size of the message being written and of the head being read
  logic [LEN_W-1:0] wr_size_q;
  logic [LEN_W-1:0] head_size_q;

  // Memory read data
  logic [DATA_W-1:0] byte_rd_q;
  logic [DESC_W-1:0] desc_rd_q;
  logic [BPTR_W-1:0] desc_rd_start;
  logic [LEN_W-1:0]  desc_rd_size;

  // Pending result and output register
  status_e           res_status_q;
  logic [DATA_W-1:0] res_byte_q;
  logic              res_last_q;
  logic [LEN_W-1:0]  res_size_q;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_byte_q;
  logic              out_last_q;
  logic [LEN_W-1:0]  out_size_q;
  logic [CNT_W-1:0]  out_count_q;
  logic [CNT_W-1:0]  out_peak_q;

  // Write-side decode
  status_e           wr_status;
  logic              wr_first;
  logic              wr_store;
  logic              wr_commit;
  logic [LEN_W-1:0]  wr_left_now;
  logic [CMP_W-1:0]  free_bytes;
  logic              no_room;
  logic [BPTR_W-1:0] byte_raddr;
  logic              byte_re;
  logic              rd_last;

  assign desc_rd_start = desc_rd_q[DESC_W-1:LEN_W];
  assign desc_rd_size  = desc_rd_q[LEN_W-1:0];

  assign free_bytes  = CMP_W'(BYTES) - CMP_W'(used_q);
  assign no_room     = (count_q >= CNT_W'(ENTRIES)) || (CMP_W'(len_q) > free_bytes);
  assign wr_left_now = wr_first ? len_q : wleft_q;
  assign rd_last     = (rleft_q <= LEN_W'(1));

  assign byte_re    = cmd_i.rd_byte || cmd_i.load_head;
  assign byte_raddr = cmd_i.load_head ? desc_rd_start : rptr_q;

  // Classify a write beat
  always_comb begin
    wr_status = ST_OK;
    wr_first  = 1'b0;
    wr_store  = 1'b0;
    if (wleft_q != '0) begin
      if (discard_q) begin
        wr_status = ST_FULL;
      end else begin
        wr_store = 1'b1;
      end
    end else if (len_q == '0) begin
      wr_status = ST_INVALID;
    end else if (no_room) begin
      wr_status = ST_FULL;
    end else begin
      wr_first = 1'b1;
      wr_store = 1'b1;
    end
  end

  assign wr_commit = cmd_i.do_write && wr_store && (wr_left_now == LEN_W'(1));

  // Next state of pointers and counts
  always_comb begin
    wptr_d      = wptr_q;
    used_d      = used_q;
    din_d       = din_q;
    dout_d      = dout_q;
    count_d     = count_q;
    peak_d      = peak_q;
    wleft_d     = wleft_q;
    discard_d   = discard_q;
    rptr_d      = rptr_q;
    rleft_d     = rleft_q;
    out_valid_d = out_valid_q;

    if (cmd_i.do_write) begin
      if (wr_store) begin
        wptr_d  = (wptr_q == BPTR_W'(BYTES - 1)) ? '0 : wptr_q + BPTR_W'(1);
        wleft_d = wr_left_now - LEN_W'(1);
        if (wr_first) begin
          discard_d = 1'b0;
        end
      end else if (wleft_q != '0) begin
        // swallow a byte of a rejected message
        wleft_d = wleft_q - LEN_W'(1);
        if (wleft_q == LEN_W'(1)) begin
          discard_d = 1'b0;
        end
      end else if (len_q != '0) begin
        // rejected first byte
        wleft_d   = len_q - LEN_W'(1);
        discard_d = (len_q != LEN_W'(1));
      end
      if (wr_commit) begin
        used_d  = used_q + USED_W'(wr_first ? len_q : wr_size_q);
        din_d   = (din_q == DPTR_W'(ENTRIES - 1)) ? '0 : din_q + DPTR_W'(1);
        count_d = count_q + CNT_W'(1);
        if (count_d > peak_q) begin
          peak_d = count_d;
        end
      end
    end

    if (cmd_i.load_head) begin
      rptr_d  = desc_rd_start;
      rleft_d = desc_rd_size;
    end

    if (cmd_i.rd_finish) begin
      rptr_d = (rptr_q == BPTR_W'(BYTES - 1)) ? '0 : rptr_q + BPTR_W'(1);
      if (rleft_q != '0) begin
        rleft_d = rleft_q - LEN_W'(1);
      end
      if (rd_last) begin
        // free the head message
        used_d = (CMP_W'(used_q) >= CMP_W'(head_size_q))
               ? USED_W'(CMP_W'(used_q) - CMP_W'(head_size_q)) : '0;
        dout_d = (dout_q == DPTR_W'(ENTRIES - 1)) ? '0 : dout_q + DPTR_W'(1);
        if (count_q != '0) begin
          count_d = count_q - CNT_W'(1);
        end
      end
    end

    if (cmd_i.do_flush) begin
      wptr_d    = '0;
      used_d    = '0;
      din_d     = '0;
      dout_d    = '0;
      count_d   = '0;
      peak_d    = '0;
      wleft_d   = '0;
      discard_d = 1'b0;
      rptr_d    = '0;
      rleft_d   = '0;
    end

    // Output register handshake
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q      <= '0;
      used_q      <= '0;
      din_q       <= '0;
      dout_q      <= '0;
      count_q     <= '0;
      peak_q      <= '0;
      wleft_q     <= '0;
      discard_q   <= 1'b0;
      rptr_q      <= '0;
      rleft_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wptr_q      <= wptr_d;
      used_q      <= used_d;
      din_q       <= din_d;
      dout_q      <= dout_d;
      count_q     <= count_d;
      peak_q      <= peak_d;
      wleft_q     <= wleft_d;
      discard_q   <= discard_d;
      rptr_q      <= rptr_d;
      rleft_q     <= rleft_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Latch the input beat and message sizes
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= cmd_e'(command_i);
      data_q <= data_byte_i;
      len_q  <= message_length_i;
    end
    if (cmd_i.do_write && wr_first) begin
      wr_size_q <= len_q;
    end
    if (cmd_i.load_head) begin
      head_size_q <= desc_rd_size;
    end
  end

  // Byte store
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write && wr_store) begin
      byte_mem[wptr_q] <= data_q;
    end
    if (byte_re) begin
      byte_rd_q <= byte_mem[byte_raddr];
    end
  end

  // Descriptor ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write && wr_first) begin
      desc_mem[din_q] <= {wptr_q, len_q};
    end
    if (cmd_i.rd_desc) begin
      desc_rd_q <= desc_mem[dout_q];
    end
  end

  // Pending result and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write) begin
      res_status_q <= wr_status;
      res_byte_q   <= '0;
      res_last_q   <= 1'b0;
      res_size_q   <= '0;
    end else if (cmd_i.set_ok || cmd_i.set_empty) begin
      res_status_q <= cmd_i.set_empty ? ST_EMPTY : ST_OK;
      res_byte_q   <= '0;
      res_last_q   <= 1'b0;
      res_size_q   <= '0;
    end else if (cmd_i.rd_finish) begin
      res_status_q <= ST_OK;
      res_byte_q   <= byte_rd_q;
      res_last_q   <= rd_last;
      res_size_q   <= head_size_q;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_byte_q   <= res_byte_q;
      out_last_q   <= res_last_q;
      out_size_q   <= res_size_q;
      out_count_q  <= count_q;
      out_peak_q   <= peak_q;
    end
  end

  // Status to the controller
  assign stat_o.cmd      = cmd_q;
  assign stat_o.rd_empty = (rleft_q == '0) && (count_q == '0);
  assign stat_o.rd_idle  = (rleft_q == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_byte_o   = out_byte_q;
  assign last_byte_o   = out_last_q;
  assign head_size_o   = out_size_q;
  assign entry_count_o = COUNT_W'(out_count_q);
  assign high_water_o  = COUNT_W'(out_peak_q);

endmodule

`default_nettype wire

@@ rtl/variable_length_message_fifo_top.sv @@
// Top level of the variable-length message FIFO: joins the sequencer and the
// datapath. Depends on vmf_pkg, vmf_ctrl and vmf_dp.
//
// Queue of byte messages in a 512-byte circular store with a 64-slot
// descriptor ring. Each input beat is one command (write byte, read byte,
// query count, flush) and returns exactly one result beat. One beat is
// worked at a time. A write, query or flush result is formed in the execute
// state and enters the output register from the response state. A read in a
// message passes the byte state between them; a first read of a message also
// passes the descriptor state before it. These steps follow the sequencer and
// the registered reads of the descriptor ring and then of the byte store. The
// next beat is accepted once the sequencer is back in idle. A result waiting
// in the output register does not block the next accept, but that beat holds
// before its hand-off until the register frees. The stores need no clearing
// after reset; the block is ready at once.
`default_nettype none

module variable_length_message_fifo_top
  import vmf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [CMD_W-1:0]   command_i,
  input  wire logic [DATA_W-1:0]  data_byte_i,
  input  wire logic [LEN_W-1:0]   message_length_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic [DATA_W-1:0]       read_byte_o,
  output logic                    last_byte_o,
  output logic [LEN_W-1:0]        head_size_o,
  output logic [COUNT_W-1:0]      entry_count_o,
  output logic [COUNT_W-1:0]      high_water_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // Sequencer
  vmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  // Stores, pointers and output register
  vmf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .stat_o           (dp_stat),
    .command_i        (command_i),
    .data_byte_i      (data_byte_i),
    .message_length_i (message_length_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .read_byte_o      (read_byte_o),
    .last_byte_o      (last_byte_o),
    .head_size_o      (head_size_o),
    .entry_count_o    (entry_count_o),
    .high_water_o     (high_water_o)
  );

endmodule

`default_nettype wire
